[sv/dga_pkg.sv]
// Shared types, constants and calendar helpers for the date adder.
`timescale 1ns / 1ps

package dga_pkg;

	localparam int unsigned YEAR_CYCLE = 400;
	localparam int unsigned MOD_STEPS  = 6;
	localparam logic [3:0]  MONTH_JAN  = 4'd1;
	localparam logic [3:0]  MONTH_FEB  = 4'd2;
	localparam logic [3:0]  MONTH_DEC  = 4'd12;

	typedef struct packed {
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [13:0] start_year;
		logic [15:0] days_to_add;
	} req_t;

	typedef struct packed {
		logic [3:0]  end_month;
		logic [4:0]  end_day;
		logic [13:0] end_year;
		logic        start_is_leap;
		logic        bad_date;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef enum logic {
		ALU_MOD,
		ALU_WALK
	} alu_mode_t;

	typedef struct packed {
		alu_mode_t  mode;
		logic [2:0] step;
	} alu_ctl_t;

	// Days of the month in a common year; zero for codes that name no month.
	function automatic logic [4:0] month_base(input logic [3:0] m);
		logic [4:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// Leap test on the year taken modulo 400.
	function automatic logic leap_of(input logic [8:0] r);
		return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

endpackage

[sv/dga_month_len.sv]
// Month length lookup with leap February.
`timescale 1ns / 1ps

module dga_month_len (
	input  logic [3:0] month,
	input  logic       leap,
	output logic [4:0] len
);

	always_comb begin
		len = dga_pkg::month_base(month);
		if (month == dga_pkg::MONTH_FEB && leap) begin
			len = 5'd29;
		end
	end

endmodule

[sv/dga_alu.sv]
// Shared subtract-and-compare unit for year reduction and month stepping.
`timescale 1ns / 1ps

module dga_alu (
	input  dga_pkg::alu_ctl_t ctl,
	input  logic [13:0]       rem,
	input  logic [15:0]       left,
	input  logic [5:0]        span,
	output logic [16:0]       diff,
	output logic              ge
);

	logic [16:0] a;
	logic [16:0] b;

	always_comb begin
		unique case (ctl.mode)
			dga_pkg::ALU_MOD: begin
				a = {3'b000, rem};
				b = 17'(dga_pkg::YEAR_CYCLE) << ctl.step;
			end
			dga_pkg::ALU_WALK: begin
				a = {1'b0, left};
				b = {11'b0, span};
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	assign diff = a - b;
	assign ge   = ~diff[16];

endmodule

[sv/gregorian_date_add_days.sv]
// Top level of the Gregorian date adder: sequencer, state registers, result register.
`timescale 1ns / 1ps

// Adds a day count to a Gregorian date and returns the later date, the leap
// flag of the starting year and a flag for a starting date that does not
// exist (month outside 1..12, day zero or past the month's end), in which
// case the date comes back unchanged. One request is worked at a time and
// req_stall stays high until it is done. A request reduces the year modulo
// 400, checks the date, walks forward one month boundary at a time, ends
// inside the last month and then loads the result; a bad date skips the
// walk. The single shared subtractor advances one month per cycle. The
// result register frees the request side: a new request is taken while the
// previous result still waits on rsp_stall.
module gregorian_date_add_days (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dga_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dga_pkg::rsp_t rsp
);

	dga_pkg::state_t   state_q;
	dga_pkg::state_t   state_nxt;
	logic [2:0]        step_q;
	logic [3:0]        mon_q;
	logic [4:0]        day_q;
	logic [13:0]       year_q;
	logic [15:0]       left_q;
	logic [13:0]       rem_q;
	logic              leap0_q;
	logic              bad_q;
	dga_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	dga_pkg::alu_ctl_t alu_ctl;
	logic [16:0]       alu_diff;
	logic              alu_ge;
	logic              leap_now;
	logic [4:0]        len;
	logic [5:0]        span;
	logic              date_bad;
	logic              req_take;
	logic              rsp_load;

	// Leap status of the current year follows from its residue modulo 400.
	assign leap_now = dga_pkg::leap_of(rem_q[8:0]);

	dga_month_len u_len (
		.month (mon_q),
		.leap  (leap_now),
		.len   (len)
	);

	// Days from the current day to the first of next month.
	assign span = 6'(len) - 6'(day_q) + 6'd1;

	dga_alu u_alu (
		.ctl  (alu_ctl),
		.rem  (rem_q),
		.left (left_q),
		.span (span),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	assign date_bad = (mon_q == 4'd0) || (mon_q > dga_pkg::MONTH_DEC) ||
		(day_q == 5'd0) || (day_q > len);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dga_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nxt = dga_pkg::ST_MOD;
				end
			end
			dga_pkg::ST_MOD: begin
				if (step_q == 3'd0) begin
					state_nxt = dga_pkg::ST_CHECK;
				end
			end
			dga_pkg::ST_CHECK: begin
				state_nxt = date_bad ? dga_pkg::ST_FINISH : dga_pkg::ST_WALK;
			end
			dga_pkg::ST_WALK: begin
				if (left_q == 16'd0) begin
					state_nxt = dga_pkg::ST_FINISH;
				end
			end
			dga_pkg::ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_nxt = dga_pkg::ST_IDLE;
				end
			end
			default: state_nxt = dga_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		req_stall    = (state_q != dga_pkg::ST_IDLE);
		req_take     = (state_q == dga_pkg::ST_IDLE) && req_valid;
		rsp_load     = (state_q == dga_pkg::ST_FINISH) && (!rsp_valid_q || !rsp_stall);
		alu_ctl.mode = (state_q == dga_pkg::ST_MOD) ? dga_pkg::ALU_MOD : dga_pkg::ALU_WALK;
		alu_ctl.step = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dga_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req_take) begin
			mon_q  <= req.start_month;
			day_q  <= req.start_day;
			year_q <= req.start_year;
			left_q <= req.days_to_add;
			rem_q  <= req.start_year;
			step_q <= 3'(dga_pkg::MOD_STEPS - 1);
			bad_q  <= 1'b0;
		end
		unique case (state_q)
			dga_pkg::ST_MOD: begin
				// Restoring reduction: drop 400 times a power of two when it fits.
				if (alu_ge) begin
					rem_q <= alu_diff[13:0];
				end
				step_q <= step_q - 3'd1;
			end
			dga_pkg::ST_CHECK: begin
				leap0_q <= leap_now;
				bad_q   <= date_bad;
			end
			dga_pkg::ST_WALK: begin
				if (left_q != 16'd0) begin
					if (alu_ge) begin
						// Cross into the next month.
						left_q <= alu_diff[15:0];
						day_q  <= 5'd1;
						if (mon_q == dga_pkg::MONTH_DEC) begin
							mon_q  <= dga_pkg::MONTH_JAN;
							year_q <= year_q + 14'd1;
							if (rem_q[8:0] == 9'(dga_pkg::YEAR_CYCLE - 1)) begin
								rem_q <= 14'd0;
							end else begin
								rem_q <= rem_q + 14'd1;
							end
						end else begin
							mon_q <= mon_q + 4'd1;
						end
					end else begin
						// Finish inside this month.
						day_q  <= day_q + left_q[4:0];
						left_q <= 16'd0;
					end
				end
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			rsp_q.end_month     <= mon_q;
			rsp_q.end_day       <= day_q;
			rsp_q.end_year      <= year_q;
			rsp_q.start_is_leap <= leap0_q;
			rsp_q.bad_date      <= bad_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_take_starts_mod: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q == dga_pkg::ST_MOD)
		else $error("accepted request did not start year reduction");

	a_residue_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dga_pkg::ST_CHECK || state_q == dga_pkg::ST_WALK) |-> rem_q < 14'd400)
		else $error("year residue not below 400");

	a_day_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dga_pkg::ST_WALK |-> (day_q != 5'd0) && (day_q <= len))
		else $error("day left its month during the walk");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == dga_pkg::ST_FINISH))
		else $error("result raised outside the finish step");

endmodule
